// File: rtl/dssm_pkg.sv
// Shared types and codes for the two-stacks-in-one-memory block.
package dssm_pkg;

    typedef enum logic [2:0] {
        REQ_PUSH_LO = 3'd0,
        REQ_PUSH_HI = 3'd1,
        REQ_POP_LO  = 3'd2,
        REQ_POP_HI  = 3'd3,
        REQ_PEEK_LO = 3'd4,
        REQ_PEEK_HI = 3'd5
    } req_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_OVERFLOW  = 2'd1,
        ST_UNDERFLOW = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        CTL_IDLE,
        CTL_EXEC,
        CTL_DONE
    } ctl_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic exec;
    } ctl_cmd_t;

endpackage

// File: rtl/dssm_ctrl.sv
// Controller state machine that sequences one item through the datapath.
module dssm_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    output logic                done,
    output dssm_pkg::ctl_cmd_t  cmd
);

    dssm_pkg::ctl_state_t state_reg;
    dssm_pkg::ctl_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= dssm_pkg::CTL_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        busy       = 1'b0;
        done       = 1'b0;
        cmd.load   = 1'b0;
        cmd.exec   = 1'b0;
        unique case (state_reg)
            dssm_pkg::CTL_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = dssm_pkg::CTL_EXEC;
                end
            end
            dssm_pkg::CTL_EXEC:
            begin
                busy       = 1'b1;
                cmd.exec   = 1'b1;
                state_next = dssm_pkg::CTL_DONE;
            end
            dssm_pkg::CTL_DONE:
            begin
                // The result is shown now, and the next item may already enter.
                done = 1'b1;
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = dssm_pkg::CTL_EXEC;
                end
                else
                begin
                    state_next = dssm_pkg::CTL_IDLE;
                end
            end
            default:
            begin
                state_next = dssm_pkg::CTL_IDLE;
            end
        endcase
    end

endmodule

// File: rtl/dssm_datapath.sv
// Datapath: request register, shared memory, fill counters and result registers.
module dssm_datapath #(
    parameter int STORE_DEPTH = 128
) (
    input  logic                clk,
    input  logic                rst_n,
    input  dssm_pkg::ctl_cmd_t  cmd,
    input  logic [2:0]          req_type,
    input  logic signed [31:0]  push_value,
    output logic signed [31:0]  read_value,
    output logic [1:0]          status,
    output logic [7:0]          lower_count,
    output logic [7:0]          upper_count
);

    localparam int AW = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
    localparam int CW = $clog2(STORE_DEPTH + 1);
    localparam logic [CW-1:0] DEPTH_C  = CW'(STORE_DEPTH);
    localparam logic [CW:0]   DEPTH_W  = (CW + 1)'(STORE_DEPTH);

    logic [31:0]        mem [STORE_DEPTH];

    logic [2:0]         req_reg;
    logic [31:0]        push_reg;
    logic [CW-1:0]      lower_fill_reg;
    logic [CW-1:0]      lower_fill_next;
    logic [CW-1:0]      upper_fill_reg;
    logic [CW-1:0]      upper_fill_next;
    dssm_pkg::status_t  status_reg;
    dssm_pkg::status_t  status_next;
    logic               rd_ok_reg;
    logic               rd_ok_next;
    logic [31:0]        rd_data_reg;

    logic [CW:0]        used;
    logic               full;
    logic               wr_en;
    logic [CW-1:0]      wr_addr;
    logic [CW-1:0]      rd_addr;

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            req_reg  <= req_type;
            push_reg <= push_value;
        end
    end

    assign used = {1'b0, lower_fill_reg} + {1'b0, upper_fill_reg};
    assign full = (used >= DEPTH_W);

    always_comb
    begin
        lower_fill_next = lower_fill_reg;
        upper_fill_next = upper_fill_reg;
        status_next     = dssm_pkg::ST_OK;
        rd_ok_next      = 1'b0;
        wr_en           = 1'b0;
        wr_addr         = lower_fill_reg;
        rd_addr         = lower_fill_reg - CW'(1);
        unique case (req_reg)
            dssm_pkg::REQ_PUSH_LO:
            begin
                if (full)
                begin
                    status_next = dssm_pkg::ST_OVERFLOW;
                end
                else
                begin
                    wr_en           = 1'b1;
                    lower_fill_next = lower_fill_reg + CW'(1);
                end
            end
            dssm_pkg::REQ_PUSH_HI:
            begin
                wr_addr = DEPTH_C - CW'(1) - upper_fill_reg;
                if (full)
                begin
                    status_next = dssm_pkg::ST_OVERFLOW;
                end
                else
                begin
                    wr_en           = 1'b1;
                    upper_fill_next = upper_fill_reg + CW'(1);
                end
            end
            dssm_pkg::REQ_POP_LO, dssm_pkg::REQ_PEEK_LO:
            begin
                if (lower_fill_reg == '0)
                begin
                    status_next = dssm_pkg::ST_UNDERFLOW;
                end
                else
                begin
                    rd_ok_next = 1'b1;
                    if (req_reg == dssm_pkg::REQ_POP_LO)
                    begin
                        lower_fill_next = lower_fill_reg - CW'(1);
                    end
                end
            end
            dssm_pkg::REQ_POP_HI, dssm_pkg::REQ_PEEK_HI:
            begin
                rd_addr = DEPTH_C - upper_fill_reg;
                if (upper_fill_reg == '0)
                begin
                    status_next = dssm_pkg::ST_UNDERFLOW;
                end
                else
                begin
                    rd_ok_next = 1'b1;
                    if (req_reg == dssm_pkg::REQ_POP_HI)
                    begin
                        upper_fill_next = upper_fill_reg - CW'(1);
                    end
                end
            end
            default:
            begin
                // Unused codes keep both fill counts, report OK and read zero.
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.exec)
        begin
            if (wr_en)
            begin
                mem[wr_addr[AW-1:0]] <= push_reg;
            end
            rd_data_reg <= mem[rd_addr[AW-1:0]];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lower_fill_reg <= '0;
            upper_fill_reg <= '0;
            status_reg     <= dssm_pkg::ST_OK;
            rd_ok_reg      <= 1'b0;
        end
        else if (cmd.exec)
        begin
            lower_fill_reg <= lower_fill_next;
            upper_fill_reg <= upper_fill_next;
            status_reg     <= status_next;
            rd_ok_reg      <= rd_ok_next;
        end
    end

    assign read_value  = rd_ok_reg ? $signed(rd_data_reg) : 32'sd0;
    assign status      = status_reg;
    assign lower_count = 8'(lower_fill_reg);
    assign upper_count = 8'(upper_fill_reg);

endmodule

// File: rtl/dual_stack_shared_memory.sv
// Top level: two LIFO stacks sharing one memory, lower grows up, upper grows down.
//
//  Channel   Handshake            Fields
//  request   start / busy         req_type, push_value
//  result    done (one cycle)     read_value, status, lower_count, upper_count
//
// An item accepted at one edge is worked in the next cycle (memory write or
// registered memory read, fill counter update) and its result is shown with
// done in the cycle after. A new item may be accepted in the cycle that done
// is high. Reset clears both fill counts; the memory is not cleared and needs
// no clearing pass. The receiver cannot stall: done lasts exactly one cycle.
module dual_stack_shared_memory #(
    parameter int STORE_DEPTH = 128
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  logic [2:0]          req_type,
    input  logic signed [31:0]  push_value,
    output logic                done,
    output logic signed [31:0]  read_value,
    output logic [1:0]          status,
    output logic [7:0]          lower_count,
    output logic [7:0]          upper_count
);

    dssm_pkg::ctl_cmd_t cmd;

    dssm_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .done  (done),
        .cmd   (cmd)
    );

    dssm_datapath #(
        .STORE_DEPTH (STORE_DEPTH)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .req_type    (req_type),
        .push_value  (push_value),
        .read_value  (read_value),
        .status      (status),
        .lower_count (lower_count),
        .upper_count (upper_count)
    );

    // An accepted item is worked on in the following cycle.
    a_accept_to_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("accepted item did not enter the work cycle");

    // The work cycle is always followed by the result strobe.
    a_busy_to_done: assert property (@(posedge clk) disable iff (!rst_n)
        busy |=> done && !busy)
        else $error("work cycle not followed by a result");

    // A result never appears without a work cycle just before it.
    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy))
        else $error("result without a preceding work cycle");

    // Refused pops and peeks carry zero data.
    a_underflow_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && (status == dssm_pkg::ST_UNDERFLOW) |-> read_value == 32'sd0)
        else $error("underflow result carries nonzero data");

endmodule
